// ===== src/crcsg_pkg.sv =====
`timescale 1ns / 1ps

package crcsg_pkg;

    // Generator size and register field widths
    localparam int MAX_DEGREE = 32;
    localparam int DEG_W      = 6;
    localparam int IDX_W      = $clog2(MAX_DEGREE);

    // Job queue between front and back (depth a power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration map
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_TAPS   = 2'd0;
    localparam logic [1:0] REG_DEGREE = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [MAX_DEGREE-1:0] TAPS_RST   = MAX_DEGREE'(11);
    localparam logic [DEG_W-1:0]      DEGREE_RST = DEG_W'(3);
    localparam logic                  MODE_GEN   = 1'b0;
    localparam logic                  MODE_CHECK = 1'b1;

    // Input word: one bit of the frame
    typedef struct packed {
        logic data_bit;
        logic frame_end;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic out_bit;
        logic is_remainder;
        logic check_error;
        logic last_of_run;
    } t_out_word;

    // Kind of work handed from front to back
    typedef enum logic {
        K_GEN,
        K_CHECK
    } t_kind;

    // One queued job: an echoed bit (plus optional remainder dump) or a verdict
    typedef struct packed {
        t_kind                 kind;
        logic                  bit_val;   // echo bit, or verdict in check mode
        logic                  dump;      // remainder follows the echo
        logic [IDX_W-1:0]      dm1;       // degree minus one
        logic [MAX_DEGREE-1:0] rem;
    } t_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // Back-end serialiser states
    typedef enum logic {
        BK_HEAD,
        BK_REM
    } t_back_state;

endpackage

// ===== src/crc_serial_generate_check_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Word
// in        input      i_in_valid / o_in_ready   i_in_word  (data_bit, frame_end)
// out       output     o_out_valid / i_out_ready o_out_word (out_bit, is_remainder,
//                                                            check_error, last_of_run)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One input word per cycle unless the queue is full; the remainder update is a single XOR step in the front.
// An echoed bit passes through the job queue and then the output register.
// A frame end in generate mode adds degree remainder bits after the echoed bit; the four-entry job
// queue absorbs the difference and then stalls the input.
// Synchronous active-low reset clears remainder, queue and serialiser and loads the registers' defaults.

module crc_serial_generate_check_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  crcsg_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output crcsg_pkg::t_out_word            o_out_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [crcsg_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [crcsg_pkg::MAX_DEGREE-1:0] r_taps;
    logic [crcsg_pkg::DEG_W-1:0]      r_degree;
    logic                             r_mode;
    logic [1:0]                       reg_idx;
    logic                             wr_en;
    crcsg_pkg::t_q_status             q_status;
    crcsg_pkg::t_job                  push_job;
    crcsg_pkg::t_job                  head_job;
    logic                             push;
    logic                             pop;
    logic                             rem_zero;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps   <= crcsg_pkg::TAPS_RST;
            r_degree <= crcsg_pkg::DEGREE_RST;
            r_mode   <= crcsg_pkg::MODE_GEN;
        end else if (wr_en) begin
            case (reg_idx)
                crcsg_pkg::REG_TAPS:   r_taps   <= pwdata[crcsg_pkg::MAX_DEGREE-1:0];
                crcsg_pkg::REG_DEGREE: r_degree <= pwdata[crcsg_pkg::DEG_W-1:0];
                crcsg_pkg::REG_MODE:   r_mode   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            crcsg_pkg::REG_TAPS:   prdata = r_taps;
            crcsg_pkg::REG_DEGREE: prdata = 32'(r_degree);
            crcsg_pkg::REG_MODE:   prdata = 32'(r_mode);
            default:               prdata = '0;
        endcase
    end

    crcsg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_taps     (r_taps),
        .i_degree   (r_degree),
        .i_mode     (r_mode),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job),
        .o_rem_zero (rem_zero)
    );

    crcsg_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    crcsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // Queue fill never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= crcsg_pkg::QCNT_W'(crcsg_pkg::QDEPTH))
        else $error("job queue over-filled");

    // An error verdict is always the frame's only and final word
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.check_error)
            |-> (o_out_word.last_of_run && !o_out_word.is_remainder && !o_out_word.out_bit))
        else $error("malformed check verdict");

    // Remainder is cleared once a frame end is taken
    a_rem_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_word.frame_end) |=> rem_zero)
        else $error("remainder not cleared after frame end");

endmodule

// ===== src/crcsg_front.sv =====
`timescale 1ns / 1ps

module crcsg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  crcsg_pkg::t_in_word             i_in_word,
    input  logic [crcsg_pkg::MAX_DEGREE-1:0] i_taps,
    input  logic [crcsg_pkg::DEG_W-1:0]     i_degree,
    input  logic                            i_mode,
    input  crcsg_pkg::t_q_status            i_q_status,
    output logic                            o_push,
    output crcsg_pkg::t_job                 o_job,
    output logic                            o_rem_zero
);

    logic [crcsg_pkg::MAX_DEGREE-1:0] r_rem;
    logic [crcsg_pkg::MAX_DEGREE-1:0] n_rem;
    logic [crcsg_pkg::MAX_DEGREE-1:0] mask;
    logic [crcsg_pkg::MAX_DEGREE-1:0] rem_m;
    logic [crcsg_pkg::MAX_DEGREE-1:0] taps_m;
    logic [crcsg_pkg::MAX_DEGREE-1:0] upd;
    logic [crcsg_pkg::IDX_W-1:0]      dm1;
    logic                             top_bit;
    logic                             accept;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_rem_zero = (r_rem == '0);

    // Effective degree: zero reads as one, large values saturate
    always_comb begin
        if (i_degree == '0) begin
            dm1 = '0;
        end else if (i_degree > crcsg_pkg::DEG_W'(crcsg_pkg::MAX_DEGREE)) begin
            dm1 = crcsg_pkg::IDX_W'(crcsg_pkg::MAX_DEGREE - 1);
        end else begin
            dm1 = crcsg_pkg::IDX_W'(i_degree - crcsg_pkg::DEG_W'(1));
        end
    end

    // Remainder mask for the current degree
    always_comb begin
        for (int i = 0; i < crcsg_pkg::MAX_DEGREE; i++) begin
            mask[i] = (crcsg_pkg::IDX_W'(i) <= dm1);
        end
    end

    assign rem_m   = r_rem & mask;
    assign taps_m  = i_taps & mask;
    assign top_bit = rem_m[dm1];

    // One division step: LFSR form for generate, long division for check
    always_comb begin
        if (i_mode == crcsg_pkg::MODE_GEN) begin
            upd = ((rem_m << 1) & mask)
                ^ ((i_in_word.data_bit ^ top_bit) ? taps_m : '0);
        end else begin
            upd = (((rem_m << 1) | crcsg_pkg::MAX_DEGREE'(i_in_word.data_bit)) & mask)
                ^ (top_bit ? taps_m : '0);
        end
        n_rem = i_in_word.frame_end ? '0 : upd;
    end

    // Job for the back end
    always_comb begin
        o_job.kind    = (i_mode == crcsg_pkg::MODE_GEN) ? crcsg_pkg::K_GEN : crcsg_pkg::K_CHECK;
        o_job.bit_val = (i_mode == crcsg_pkg::MODE_GEN) ? i_in_word.data_bit : (upd != '0);
        o_job.dump    = i_in_word.frame_end;
        o_job.dm1     = dm1;
        o_job.rem     = upd;
        // check mode only reports at the end of the frame
        o_push        = accept && ((i_mode == crcsg_pkg::MODE_GEN) || i_in_word.frame_end);
    end

    // Running remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (accept) begin
            r_rem <= n_rem;
        end
    end

endmodule

// ===== src/crcsg_fifo.sv =====
`timescale 1ns / 1ps

module crcsg_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crcsg_pkg::t_job       i_job,
    input  logic                  i_pop,
    output crcsg_pkg::t_job       o_job,
    output crcsg_pkg::t_q_status  o_status
);

    crcsg_pkg::t_job                 r_mem [crcsg_pkg::QDEPTH];
    logic [crcsg_pkg::QPTR_W-1:0]    r_wr;
    logic [crcsg_pkg::QPTR_W-1:0]    r_rd;
    logic [crcsg_pkg::QCNT_W-1:0]    r_cnt;

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_cnt == crcsg_pkg::QCNT_W'(crcsg_pkg::QDEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_status.count = r_cnt;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + crcsg_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + crcsg_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + crcsg_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - crcsg_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ===== src/crcsg_back.sv =====
`timescale 1ns / 1ps

module crcsg_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crcsg_pkg::t_q_status  i_q_status,
    input  crcsg_pkg::t_job       i_job,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output crcsg_pkg::t_out_word  o_out_word
);

    crcsg_pkg::t_back_state       r_state;
    crcsg_pkg::t_back_state       n_state;
    logic [crcsg_pkg::IDX_W-1:0]  r_idx;
    logic [crcsg_pkg::IDX_W-1:0]  n_idx;
    logic                         r_out_valid;
    crcsg_pkg::t_out_word         r_out_word;
    crcsg_pkg::t_out_word         n_word;
    logic                         load;
    logic                         emit;

    assign load        = !r_out_valid || i_out_ready;
    assign emit        = !i_q_status.empty && load;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crcsg_pkg::BK_HEAD: begin
                if (emit && (i_job.kind == crcsg_pkg::K_GEN) && i_job.dump) begin
                    n_state = crcsg_pkg::BK_REM;
                end
            end
            crcsg_pkg::BK_REM: begin
                if (emit && (r_idx == '0)) begin
                    n_state = crcsg_pkg::BK_HEAD;
                end
            end
            default: begin
                n_state = crcsg_pkg::BK_HEAD;
            end
        endcase
    end

    // Output word, pop and remainder bit index
    always_comb begin
        n_word = '0;
        o_pop  = 1'b0;
        n_idx  = r_idx;
        case (r_state)
            crcsg_pkg::BK_HEAD: begin
                if (i_job.kind == crcsg_pkg::K_CHECK) begin
                    n_word.check_error = i_job.bit_val;
                    n_word.last_of_run = 1'b1;
                    o_pop              = emit;
                end else begin
                    n_word.out_bit = i_job.bit_val;
                    o_pop          = emit && !i_job.dump;
                    n_idx          = i_job.dm1;
                end
            end
            crcsg_pkg::BK_REM: begin
                // remainder bits, most significant first
                n_word.out_bit      = i_job.rem[r_idx];
                n_word.is_remainder = 1'b1;
                n_word.last_of_run  = (r_idx == '0);
                o_pop               = emit && (r_idx == '0);
                n_idx               = r_idx - crcsg_pkg::IDX_W'(1);
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    // State and bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crcsg_pkg::BK_HEAD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_idx <= n_idx;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word <= n_word;
        end
    end

endmodule
